### rtl/rgb_to_ypbpr_converter_defines.svh
// ----------------------------------------------------------------------------
// RGB to YPbPr converter assertion macros
// Shared property templates for the converter's port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YPBPR_CONVERTER_DEFINES_SVH
`define RGB_TO_YPBPR_CONVERTER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define R2Y_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define R2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/r2ypbpr_pkg.sv
// ----------------------------------------------------------------------------
// RGB to YPbPr converter package
// Payload types, BT.601 coefficients and fixed-point limits.
// ----------------------------------------------------------------------------
package r2ypbpr_pkg;

    // Field widths fixed by the interface
    localparam int FIELD_BITS      = 16;
    localparam int CFG_BITS        = 16;
    localparam int COEF_BITS       = 16;

    // Default sample width and reset of the max-value register
    localparam int SAMPLE_BITS_DEF = 16;
    localparam logic [CFG_BITS-1:0] MAX_VALUE_RESET = 16'd255;

    // Quotient bits produced by the divider and bits per divider stage
    localparam int Q_BITS           = 16;
    localparam int DIV_BITS_PER_STG = 2;

    // Q1.15 saturation limits
    localparam int Q_ONE  = 32768;
    localparam int Q_HALF = 16384;

    // Channel order of the matrix rows and of the sample columns
    localparam int NUM_CH = 3;
    localparam int CH_Y   = 0;
    localparam int CH_PB  = 1;
    localparam int CH_PR  = 2;

    // BT.601 matrix in Q1.15, rows Y/Pb/Pr, columns R/G/B
    localparam logic signed [COEF_BITS-1:0] COEF [NUM_CH][NUM_CH] = '{
        '{ 16'sd9798,   16'sd19235,  16'sd3736 },
        '{-16'sd5529,  -16'sd10855,  16'sd16384},
        '{ 16'sd16384, -16'sd13720, -16'sd2664 }
    };

    typedef struct packed {
        logic [FIELD_BITS-1:0] red_sample;
        logic [FIELD_BITS-1:0] green_sample;
        logic [FIELD_BITS-1:0] blue_sample;
    } t_pixel_in;

    typedef struct packed {
        logic        [FIELD_BITS-1:0] luma;
        logic signed [FIELD_BITS-1:0] blue_diff;
        logic signed [FIELD_BITS-1:0] red_diff;
    } t_pixel_out;

endpackage

### rtl/rgb_to_ypbpr_converter.sv
// ----------------------------------------------------------------------------
// RGB to YPbPr converter
// BT.601 color space conversion with normalization by a programmable
// maximum sample value, Q1.15 saturated outputs.
// ----------------------------------------------------------------------------
// Converts one RGB pixel per clock into Y, Pb and Pr in Q1.15 (32768 = 1.0).
// Each weighted sum is divided by max_value (zero counts as one) and rounded
// to nearest, halves away from zero; Y saturates to 0..1.0, Pb and Pr to
// +/-0.5. Throughput is one pixel per clock when the output side is ready.
// The restoring divider resolves two quotient bits per stage for all three
// channels in parallel. Samples and max_value keep only their low
// SAMPLE_BITS bits. Write max_value only while no request is in flight; the
// configuration port is always ready.
module rgb_to_ypbpr_converter
    import r2ypbpr_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_pixel_in           i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_pixel_out          o_out_data
);

    localparam int W       = SAMPLE_BITS;
    localparam int SW      = W + 17;           // signed products and sums
    localparam int MW      = W + 16;           // sum magnitude
    localparam int NW      = W + 18;           // 2*|sum| + divisor
    localparam int DW      = W + 1;            // 2*divisor and remainder
    localparam int HW      = NW - Q_BITS;      // numerator above quotient bits
    localparam int DIV_STG = Q_BITS / DIV_BITS_PER_STG;
    localparam int ST_IN   = 0;
    localparam int ST_PRD  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_MAG  = 3;
    localparam int ST_DIV0 = 4;
    localparam int ST_OUT  = ST_DIV0 + DIV_STG;
    localparam int NST     = ST_OUT + 1;

    typedef struct packed {
        logic [DW-1:0]     rem;
        logic [Q_BITS-1:0] lo;
        logic [Q_BITS-1:0] quo;
    } t_div;

    // Resolve DIV_BITS_PER_STG quotient bits by restoring division
    function automatic t_div div_steps(input t_div a, input logic [DW-1:0] dv);
        t_div        v;
        logic [DW:0] t;
        v = a;
        for (int b = 0; b < DIV_BITS_PER_STG; b++) begin
            t    = {v.rem, v.lo[Q_BITS-1]};
            v.lo = {v.lo[Q_BITS-2:0], 1'b0};
            if (t >= {1'b0, dv}) begin
                v.rem = DW'(t - {1'b0, dv});
                v.quo = {v.quo[Q_BITS-2:0], 1'b1};
            end else begin
                v.rem = t[DW-1:0];
                v.quo = {v.quo[Q_BITS-2:0], 1'b0};
            end
        end
        return v;
    endfunction

    logic [CFG_BITS-1:0] r_max;
    logic [W-1:0]        w_dval;
    logic [DW-1:0]       w_div2;

    logic [NST-1:0]      r_vld;
    logic [NST-1:0]      w_en;

    logic [W-1:0]           r_smp [NUM_CH];
    logic [W-1:0]           n_smp [NUM_CH];
    logic signed [SW-1:0]   r_prd [NUM_CH][NUM_CH];
    logic signed [SW-1:0]   n_prd [NUM_CH][NUM_CH];
    logic signed [SW-1:0]   r_sum [NUM_CH];
    logic signed [SW-1:0]   n_sum [NUM_CH];
    logic [NW-1:0]          r_num [NUM_CH];
    logic [NW-1:0]          n_num [NUM_CH];
    logic                   r_neg [NUM_CH];
    logic                   n_neg [NUM_CH];
    t_div                   r_div [DIV_STG][NUM_CH];
    t_div                   n_div [DIV_STG][NUM_CH];
    logic                   r_ovf [DIV_STG][NUM_CH];
    logic                   n_ovf [DIV_STG][NUM_CH];
    logic                   r_dneg [DIV_STG][NUM_CH];
    logic                   n_dneg [DIV_STG][NUM_CH];
    logic [FIELD_BITS-1:0]  w_res [NUM_CH];
    t_pixel_out             r_out;
    t_pixel_out             n_out;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_VALUE_RESET;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    // Effective divisor: low sample bits, zero counts as one
    always_comb begin
        w_dval = r_max[W-1:0];
        if (w_dval == '0) begin
            w_dval = {{(W-1){1'b0}}, 1'b1};
        end
        w_div2 = {w_dval, 1'b0};
    end

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[ST_IN];
    assign o_out_valid = r_vld[ST_OUT];
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Capture samples, products, sums and numerators
    always_comb begin
        n_smp[0] = i_in_data.red_sample[W-1:0];
        n_smp[1] = i_in_data.green_sample[W-1:0];
        n_smp[2] = i_in_data.blue_sample[W-1:0];
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                n_prd[ch][c] = SW'(COEF[ch][c]) * $signed(SW'({1'b0, r_smp[c]}));
            end
            n_sum[ch] = r_prd[ch][0] + r_prd[ch][1] + r_prd[ch][2];
            n_neg[ch] = r_sum[ch][SW-1];
            n_num[ch] = NW'({MW'(r_sum[ch][SW-1] ? -r_sum[ch] : r_sum[ch]), 1'b0})
                      + NW'(w_dval);
        end
    end

    // Divider stages: overflow check in the first, two bits per stage
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_div[0][ch]  = div_steps('{rem: r_num[ch][Q_BITS +: DW],
                                        lo:  r_num[ch][Q_BITS-1:0],
                                        quo: '0}, w_div2);
            n_ovf[0][ch]  = r_num[ch][NW-1:Q_BITS] >= HW'(w_div2);
            n_dneg[0][ch] = r_neg[ch];
            for (int j = 1; j < DIV_STG; j++) begin
                n_div[j][ch]  = div_steps(r_div[j-1][ch], w_div2);
                n_ovf[j][ch]  = r_ovf[j-1][ch];
                n_dneg[j][ch] = r_dneg[j-1][ch];
            end
        end
    end

    // Saturate and restore the sign
    always_comb begin
        logic [Q_BITS-1:0] lim;
        logic [Q_BITS-1:0] q;
        logic [Q_BITS-1:0] qc;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lim = (ch == CH_Y) ? Q_BITS'(Q_ONE) : Q_BITS'(Q_HALF);
            q   = r_div[DIV_STG-1][ch].quo;
            qc  = (r_ovf[DIV_STG-1][ch] || q > lim) ? lim : q;
            if (ch == CH_Y) begin
                w_res[ch] = r_dneg[DIV_STG-1][ch] ? '0 : FIELD_BITS'(qc);
            end else begin
                w_res[ch] = r_dneg[DIV_STG-1][ch] ? FIELD_BITS'(-qc) : FIELD_BITS'(qc);
            end
        end
        n_out.luma      = w_res[CH_Y];
        n_out.blue_diff = w_res[CH_PB];
        n_out.red_diff  = w_res[CH_PR];
    end

    // Payload registers, loaded when their stage advances
    always_ff @(posedge i_clk) begin
        if (w_en[ST_IN]) begin
            r_smp <= n_smp;
        end
        if (w_en[ST_PRD]) begin
            r_prd <= n_prd;
        end
        if (w_en[ST_SUM]) begin
            r_sum <= n_sum;
        end
        if (w_en[ST_MAG]) begin
            r_num <= n_num;
            r_neg <= n_neg;
        end
        for (int j = 0; j < DIV_STG; j++) begin
            if (w_en[ST_DIV0+j]) begin
                r_div[j]  <= n_div[j];
                r_ovf[j]  <= n_ovf[j];
                r_dneg[j] <= n_dneg[j];
            end
        end
        if (w_en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/r2ypbpr_checker.sv
// ----------------------------------------------------------------------------
// RGB to YPbPr converter port checker
// Range and flow checks on the converter's ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_ypbpr_converter_defines.svh"

module r2ypbpr_checker
    import r2ypbpr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_pixel_out o_out_data
);

    // Hold saturation limits on every delivered result
    `R2Y_ASSERT_IMPL(a_luma_range, i_clk, i_rst_n, o_out_valid,
                     o_out_data.luma <= Q_ONE, "luma above 1.0")
    `R2Y_ASSERT_IMPL(a_pb_range, i_clk, i_rst_n, o_out_valid,
                     (o_out_data.blue_diff >= -Q_HALF) && (o_out_data.blue_diff <= Q_HALF),
                     "Pb outside +/-0.5")
    `R2Y_ASSERT_IMPL(a_pr_range, i_clk, i_rst_n, o_out_valid,
                     (o_out_data.red_diff >= -Q_HALF) && (o_out_data.red_diff <= Q_HALF),
                     "Pr outside +/-0.5")

    // Hold a stalled result
    `R2Y_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
                     o_out_valid && $stable(o_out_data), "stalled result changed")

    // Accept a request whenever the output side drains
    `R2Y_ASSERT_IMPL(a_in_ready, i_clk, i_rst_n, !o_out_valid || i_out_ready,
                     o_in_ready, "input blocked with a free pipeline")

endmodule

bind rgb_to_ypbpr_converter r2ypbpr_checker u_r2ypbpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
